>>> rtl/ffa_pkg.sv
// Package for the first-fit aligned page allocator.
// Holds the word types, result codes, controller states and the command and
// status structs shared by ffa_ctrl, ffa_dp and the top level. No dependencies.
package ffa_pkg;

	localparam int ADDR_BITS = 56;
	localparam int SUM_BITS  = 57;
	localparam int EXT_BITS  = 58;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_ZERO_BASE   = 3'd1,
		ST_TABLE_FULL  = 3'd2,
		ST_TOO_SMALL   = 3'd3,
		ST_MANAGED     = 3'd4,
		ST_BAD_ALIGN   = 3'd5,
		ST_NO_MEMORY   = 3'd6,
		ST_NO_DESC     = 3'd7
	} status_e;

	typedef enum logic [0:0] {
		OP_ADD_REGION = 1'b0,
		OP_ALLOCATE   = 1'b1
	} operation_e;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_A_PREP,
		DP_A_SIZE,
		DP_IDX_INC,
		DP_A_COMMIT,
		DP_L_PREP,
		DP_L_HEAD,
		DP_CALC,
		DP_FIT,
		DP_NEXT,
		DP_SPLIT_NEW,
		DP_SPLIT_CUR,
		DP_TRIM_PRE,
		DP_TRIM_POST,
		DP_UNLINK,
		DP_ALLOC_OK,
		DP_FAIL,
		DP_EMIT
	} dp_op_e;

	typedef enum logic [4:0] {
		S_IDLE,
		S_A_PREP,
		S_A_SIZE,
		S_A_CHK,
		S_A_SCAN,
		S_A_CMP,
		S_L_PREP,
		S_L_CHK,
		S_L_REG,
		S_L_REGD,
		S_L_EXT,
		S_L_CALC,
		S_L_FIT,
		S_L_DEC,
		S_L_SPLIT,
		S_L_DONE,
		S_FIN
	} ctrl_state_e;

	typedef struct packed {
		logic                 operation;
		logic [ADDR_BITS-1:0] address;
		logic [ADDR_BITS-1:0] length;
		logic [ADDR_BITS-1:0] alignment;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ADDR_BITS-1:0] granted_address;
		logic [SUM_BITS-1:0]  total_managed;
		logic [SUM_BITS-1:0]  total_free;
	} rsp_t;

	typedef struct packed {
		dp_op_e  op;
		status_e code;
	} dp_cmd_t;

	typedef struct packed {
		status_e a_code;
		logic    idx_end;
		logic    overlap;
		logic    spare_empty;
		logic    bad_align;
		logic    no_mem;
		logic    unused_short;
		logic    walk_end;
		logic    fit;
		logic    pre;
		logic    post;
	} dp_stat_t;

endpackage

>>> rtl/first_fit_aligned_page_allocator.sv
// Top level of the first-fit aligned page allocator.
// Joins ffa_ctrl and ffa_dp; uses ffa_pkg.
//
//   channel  dir  handshake             word
//   req      in   req_valid/req_stall   req_t: operation, address, length, alignment
//   rsp      out  rsp_valid/rsp_stall   rsp_t: status, granted_address, totals
//
// Add region scans the held regions, and allocate walks the regions and their
// extent lists, one entry at a time before the result word is formed.
// One word in flight; req_stall is high from acceptance until its result is
// registered, which waits only while a previous result is held by rsp_stall.
// Reset empties the region table and refills the spare stack at once.
module first_fit_aligned_page_allocator import ffa_pkg::*; #(
	parameter int MAX_REGIONS = 16,
	parameter int MAX_EXTENTS = 64,
	parameter int PAGE_SHIFT  = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	dp_cmd_t  cmd;
	dp_stat_t st;

	ffa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_operation (req.operation),
		.req_stall     (req_stall),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.cmd           (cmd),
		.st            (st)
	);

	ffa_dp #(
		.MAX_REGIONS (MAX_REGIONS),
		.MAX_EXTENTS (MAX_EXTENTS),
		.PAGE_SHIFT  (PAGE_SHIFT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.st     (st),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> rtl/ffa_ctrl.sv
// Sequencing state machine of the page allocator.
// Drives dp_cmd_t to ffa_dp and reads dp_stat_t back; uses ffa_pkg.
module ffa_ctrl import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_operation,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t st
);

	ctrl_state_e state_q, state_n;
	logic        out_valid_q;
	logic        emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_n  = state_q;
		cmd.op   = DP_NOP;
		cmd.code = ST_OK;
		emit     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = DP_LOAD;
					state_n = (req_operation == OP_ALLOCATE) ? S_L_PREP : S_A_PREP;
				end
			end
			S_A_PREP: begin
				cmd.op  = DP_A_PREP;
				state_n = S_A_SIZE;
			end
			S_A_SIZE: begin
				cmd.op  = DP_A_SIZE;
				state_n = S_A_CHK;
			end
			S_A_CHK: begin
				if (st.a_code != ST_OK) begin
					cmd.op   = DP_FAIL;
					cmd.code = st.a_code;
					state_n  = S_FIN;
				end else begin
					state_n = S_A_SCAN;
				end
			end
			S_A_SCAN: begin
				if (!st.idx_end) begin
					state_n = S_A_CMP;
				end else if (st.spare_empty) begin
					cmd.op   = DP_FAIL;
					cmd.code = ST_NO_DESC;
					state_n  = S_FIN;
				end else begin
					cmd.op  = DP_A_COMMIT;
					state_n = S_FIN;
				end
			end
			S_A_CMP: begin
				if (st.overlap) begin
					cmd.op   = DP_FAIL;
					cmd.code = ST_MANAGED;
					state_n  = S_FIN;
				end else begin
					cmd.op  = DP_IDX_INC;
					state_n = S_A_SCAN;
				end
			end
			S_L_PREP: begin
				cmd.op  = DP_L_PREP;
				state_n = S_L_CHK;
			end
			S_L_CHK: begin
				if (st.bad_align) begin
					cmd.op   = DP_FAIL;
					cmd.code = ST_BAD_ALIGN;
					state_n  = S_FIN;
				end else if (st.no_mem) begin
					cmd.op   = DP_FAIL;
					cmd.code = ST_NO_MEMORY;
					state_n  = S_FIN;
				end else begin
					state_n = S_L_REG;
				end
			end
			S_L_REG: begin
				if (st.idx_end) begin
					cmd.op   = DP_FAIL;
					cmd.code = ST_NO_MEMORY;
					state_n  = S_FIN;
				end else begin
					state_n = S_L_REGD;
				end
			end
			S_L_REGD: begin
				if (st.unused_short) begin
					cmd.op  = DP_IDX_INC;
					state_n = S_L_REG;
				end else begin
					cmd.op  = DP_L_HEAD;
					state_n = S_L_EXT;
				end
			end
			S_L_EXT: begin
				if (st.walk_end) begin
					cmd.op  = DP_IDX_INC;
					state_n = S_L_REG;
				end else begin
					state_n = S_L_CALC;
				end
			end
			S_L_CALC: begin
				cmd.op  = DP_CALC;
				state_n = S_L_FIT;
			end
			S_L_FIT: begin
				cmd.op  = DP_FIT;
				state_n = S_L_DEC;
			end
			S_L_DEC: begin
				if (!st.fit) begin
					cmd.op  = DP_NEXT;
					state_n = S_L_EXT;
				end else if (st.pre && st.post) begin
					if (st.spare_empty) begin
						cmd.op   = DP_FAIL;
						cmd.code = ST_NO_DESC;
						state_n  = S_FIN;
					end else begin
						cmd.op  = DP_SPLIT_NEW;
						state_n = S_L_SPLIT;
					end
				end else if (st.pre) begin
					cmd.op  = DP_TRIM_PRE;
					state_n = S_L_DONE;
				end else if (st.post) begin
					cmd.op  = DP_TRIM_POST;
					state_n = S_L_DONE;
				end else begin
					cmd.op  = DP_UNLINK;
					state_n = S_L_DONE;
				end
			end
			S_L_SPLIT: begin
				cmd.op  = DP_SPLIT_CUR;
				state_n = S_L_DONE;
			end
			S_L_DONE: begin
				cmd.op  = DP_ALLOC_OK;
				state_n = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || !rsp_stall) begin
					cmd.op  = DP_EMIT;
					emit    = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

>>> rtl/ffa_dp.sv
// Datapath of the page allocator: region table, extent descriptors, spare
// stack, running totals and the result word register. Uses ffa_pkg.
module ffa_dp import ffa_pkg::*; #(
	parameter int MAX_REGIONS = 16,
	parameter int MAX_EXTENTS = 64,
	parameter int PAGE_SHIFT  = 12
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dp_cmd_t  cmd,
	output dp_stat_t st,
	input  req_t     req,
	output rsp_t     rsp
);

	localparam int AB = ADDR_BITS;
	localparam int XW = EXT_BITS;
	localparam int RW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int UW = $clog2(MAX_REGIONS + 1);
	localparam int EW = $clog2(MAX_EXTENTS);
	localparam int LW = $clog2(MAX_EXTENTS + 1);
	localparam logic [XW-1:0] PAGE    = XW'(1) << PAGE_SHIFT;
	localparam logic [XW-1:0] PMASK   = PAGE - XW'(1);
	localparam logic [XW-1:0] LIMIT   = XW'(1) << AB;
	localparam logic [UW-1:0] MAXR    = UW'(MAX_REGIONS);
	localparam logic [LW-1:0] NO_LINK = LW'(MAX_EXTENTS);

	// region table
	logic [AB-1:0] rstart_m  [MAX_REGIONS];
	logic [AB-1:0] rsize_m   [MAX_REGIONS];
	logic [AB-1:0] runused_m [MAX_REGIONS];
	logic [LW-1:0] rhead_m   [MAX_REGIONS];
	logic [AB-1:0] rs_rd, rsz_rd, run_rd;
	logic [LW-1:0] rh_rd;
	// extent descriptors
	logic [AB-1:0] estart_m [MAX_EXTENTS];
	logic [AB-1:0] esize_m  [MAX_EXTENTS];
	logic [LW-1:0] elink_m  [MAX_EXTENTS];
	logic [AB-1:0] es_rd, esz_rd;
	logic [LW-1:0] el_rd;
	// spare stack
	logic [EW-1:0] sp_m [MAX_EXTENTS];
	logic [EW-1:0] sp_rd, sp_pos_q;
	logic          sp_vld_q;

	logic [AB-1:0]  addr_q, len_q, align_q, am1_q, unused_q, s_q;
	logic [XW-1:0]  base_q, end_q, size_q, e_q, a_q, aend_q;
	logic           neg_q, bad_q, fit_q, pre_q, post_q;
	logic [UW-1:0]  idx_q, used_q;
	logic [LW-1:0]  cur_q, prev_q, link_q, steps_q, count_q, low_q;
	logic [EW-1:0]  d_q;
	logic [SUM_BITS-1:0] msum_q, fsum_q;
	status_e        res_status_q;
	logic [AB-1:0]  res_gran_q;
	rsp_t           rsp_q;
	status_e        a_code;

	logic [RW-1:0] ri;
	logic [LW-1:0] pop_cnt;
	logic [EW-1:0] sp_pos, d_new;
	logic [XW-1:0] msum_n, fsum_n, tail, head_part;

	logic          rg_we_all, rg_we_unused, rg_we_head;
	logic [AB-1:0] rg_unused_wd;
	logic [LW-1:0] rg_head_wd;
	logic          ex_we_s, ex_we_z, ex_we_l, sp_we;
	logic [EW-1:0] ex_addr;
	logic [AB-1:0] ex_s_wd, ex_z_wd;
	logic [LW-1:0] ex_l_wd;

	assign ri      = idx_q[RW-1:0];
	assign pop_cnt = count_q - LW'(1);
	assign sp_pos  = pop_cnt[EW-1:0];
	// entries below the lowest fill level ever reached still hold their index
	assign d_new   = sp_vld_q ? sp_rd : sp_pos_q;
	assign msum_n  = XW'(msum_q) + size_q;
	assign fsum_n  = XW'(fsum_q) + size_q;
	assign tail    = e_q - aend_q;
	assign head_part = a_q - XW'(s_q);

	always_comb begin
		rg_we_all    = 1'b0;
		rg_we_unused = 1'b0;
		rg_we_head   = 1'b0;
		rg_unused_wd = size_q[AB-1:0];
		rg_head_wd   = LW'(d_new);
		ex_we_s      = 1'b0;
		ex_we_z      = 1'b0;
		ex_we_l      = 1'b0;
		sp_we        = 1'b0;
		ex_addr      = cur_q[EW-1:0];
		ex_s_wd      = aend_q[AB-1:0];
		ex_z_wd      = tail[AB-1:0];
		ex_l_wd      = link_q;
		case (cmd.op)
			DP_A_COMMIT: begin
				rg_we_all    = 1'b1;
				rg_we_unused = 1'b1;
				rg_we_head   = 1'b1;
				ex_we_s      = 1'b1;
				ex_we_z      = 1'b1;
				ex_we_l      = 1'b1;
				ex_addr      = d_new;
				ex_s_wd      = base_q[AB-1:0];
				ex_z_wd      = size_q[AB-1:0];
				ex_l_wd      = NO_LINK;
			end
			DP_SPLIT_NEW: begin
				ex_we_s = 1'b1;
				ex_we_z = 1'b1;
				ex_we_l = 1'b1;
				ex_addr = d_new;
			end
			DP_SPLIT_CUR: begin
				ex_we_z = 1'b1;
				ex_we_l = 1'b1;
				ex_z_wd = head_part[AB-1:0];
				ex_l_wd = LW'(d_q);
			end
			DP_TRIM_PRE: begin
				ex_we_z = 1'b1;
				ex_z_wd = head_part[AB-1:0];
			end
			DP_TRIM_POST: begin
				ex_we_s = 1'b1;
				ex_we_z = 1'b1;
			end
			DP_UNLINK: begin
				sp_we = (count_q < NO_LINK);
				if (prev_q == NO_LINK) begin
					rg_we_head = 1'b1;
					rg_head_wd = link_q;
				end else begin
					ex_we_l = 1'b1;
					ex_addr = prev_q[EW-1:0];
				end
			end
			DP_ALLOC_OK: begin
				rg_we_unused = 1'b1;
				rg_unused_wd = unused_q - size_q[AB-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rg_we_all) begin
			rstart_m[ri] <= base_q[AB-1:0];
			rsize_m[ri]  <= size_q[AB-1:0];
		end
		if (rg_we_unused)
			runused_m[ri] <= rg_unused_wd;
		if (rg_we_head)
			rhead_m[ri] <= rg_head_wd;
		rs_rd  <= rstart_m[ri];
		rsz_rd <= rsize_m[ri];
		run_rd <= runused_m[ri];
		rh_rd  <= rhead_m[ri];
	end

	always_ff @(posedge clk) begin
		if (ex_we_s)
			estart_m[ex_addr] <= ex_s_wd;
		if (ex_we_z)
			esize_m[ex_addr] <= ex_z_wd;
		if (ex_we_l)
			elink_m[ex_addr] <= ex_l_wd;
		es_rd  <= estart_m[cur_q[EW-1:0]];
		esz_rd <= esize_m[cur_q[EW-1:0]];
		el_rd  <= elink_m[cur_q[EW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (sp_we)
			sp_m[count_q[EW-1:0]] <= cur_q[EW-1:0];
		sp_rd    <= sp_m[sp_pos];
		sp_pos_q <= sp_pos;
		sp_vld_q <= (pop_cnt >= low_q);
	end

	// allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			count_q <= NO_LINK;
			low_q   <= NO_LINK;
			msum_q  <= '0;
			fsum_q  <= '0;
		end else begin
			case (cmd.op)
				DP_A_COMMIT: begin
					used_q  <= used_q + UW'(1);
					count_q <= pop_cnt;
					if (pop_cnt < low_q)
						low_q <= pop_cnt;
					msum_q <= msum_n[XW-1] ? '1 : msum_n[SUM_BITS-1:0];
					fsum_q <= fsum_n[XW-1] ? '1 : fsum_n[SUM_BITS-1:0];
				end
				DP_SPLIT_NEW: begin
					count_q <= pop_cnt;
					if (pop_cnt < low_q)
						low_q <= pop_cnt;
				end
				DP_UNLINK: begin
					if (count_q < NO_LINK)
						count_q <= count_q + LW'(1);
				end
				DP_ALLOC_OK: fsum_q <= fsum_q - size_q[SUM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// working registers and result
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				addr_q  <= req.address;
				len_q   <= req.length;
				align_q <= req.alignment;
				idx_q   <= '0;
			end
			DP_A_PREP: begin
				base_q <= (XW'(addr_q) + PMASK) & ~PMASK;
				end_q  <= XW'(addr_q) + XW'(len_q);
			end
			DP_A_SIZE: begin
				neg_q  <= base_q > end_q;
				size_q <= (end_q - base_q) & ~PMASK;
			end
			DP_IDX_INC: idx_q <= idx_q + UW'(1);
			DP_A_COMMIT: begin
				res_status_q <= ST_OK;
				res_gran_q   <= '0;
			end
			DP_L_PREP: begin
				size_q <= (len_q == '0) ? PAGE : ((XW'(len_q) + PMASK) & ~PMASK);
				bad_q  <= (XW'(align_q) < PAGE) || ((align_q & (align_q - AB'(1))) != '0);
				am1_q  <= align_q - AB'(1);
			end
			DP_L_HEAD: begin
				cur_q    <= rh_rd;
				prev_q   <= NO_LINK;
				steps_q  <= '0;
				unused_q <= run_rd;
			end
			DP_CALC: begin
				s_q     <= es_rd;
				link_q  <= el_rd;
				e_q     <= XW'(es_rd) + XW'(esz_rd);
				a_q     <= (XW'(es_rd) + XW'(am1_q)) & ~XW'(am1_q);
				steps_q <= steps_q + LW'(1);
			end
			DP_FIT: begin
				aend_q <= a_q + size_q;
				fit_q  <= (a_q <= e_q) && (size_q <= e_q - a_q);
				pre_q  <= a_q != XW'(s_q);
				post_q <= (e_q - a_q) > size_q;
			end
			DP_NEXT: begin
				prev_q <= cur_q;
				cur_q  <= link_q;
			end
			DP_SPLIT_NEW: d_q <= d_new;
			DP_ALLOC_OK: begin
				res_status_q <= ST_OK;
				res_gran_q   <= a_q[AB-1:0];
			end
			DP_FAIL: begin
				res_status_q <= cmd.code;
				res_gran_q   <= '0;
			end
			DP_EMIT: begin
				rsp_q.status          <= res_status_q;
				rsp_q.granted_address <= res_gran_q;
				rsp_q.total_managed   <= msum_q;
				rsp_q.total_free      <= fsum_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (addr_q == '0)
			a_code = ST_ZERO_BASE;
		else if (used_q >= MAXR)
			a_code = ST_TABLE_FULL;
		else if (neg_q || size_q < PAGE || (base_q + size_q) > LIMIT)
			a_code = ST_TOO_SMALL;
		else
			a_code = ST_OK;
	end

	assign st.a_code       = a_code;
	assign st.idx_end      = idx_q >= used_q;
	assign st.overlap      = (XW'(rs_rd) <= base_q) && (base_q <= XW'(rs_rd) + XW'(rsz_rd));
	assign st.spare_empty  = count_q == '0;
	assign st.bad_align    = bad_q;
	assign st.no_mem       = XW'(fsum_q) < size_q;
	assign st.unused_short = XW'(run_rd) < size_q;
	assign st.walk_end     = (cur_q >= NO_LINK) || (steps_q >= NO_LINK);
	assign st.fit          = fit_q;
	assign st.pre          = pre_q;
	assign st.post         = post_q;
	assign rsp             = rsp_q;

endmodule

>>> tb/sv/ffa_checker.sv
// Checker for the first-fit aligned page allocator: watches both channels,
// keeps its own copy of the region and extent tables and compares each result.
// Depends on ffa_pkg for the word types and status codes.
`timescale 1ns / 100ps

module ffa_checker import ffa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   errors,
	output int   pending
);
	localparam int        NREG    = 16;
	localparam int        NEXT    = 64;
	localparam bit [63:0] PG      = 64'h1000;
	localparam bit [63:0] PG_MASK = 64'hfff;
	localparam bit [63:0] LIMIT   = 64'h1 << ADDR_BITS;
	localparam bit [63:0] SUM_MAX = (64'h1 << SUM_BITS) - 1;

	bit [63:0] rg_start [NREG];
	bit [63:0] rg_size  [NREG];
	bit [63:0] rg_free  [NREG];
	int        rg_head  [NREG];
	int        rg_count;
	bit [63:0] ext_start [NEXT];
	bit [63:0] ext_size  [NEXT];
	int        ext_link  [NEXT];
	int        spare     [NEXT];
	int        spare_top;
	bit [63:0] managed_bytes, free_total;
	rsp_t      expected_rsp [$];

	initial begin
		for (int i = 0; i < NEXT; i++) spare[i] = i;
		spare_top = NEXT;
		rg_count = 0;
		managed_bytes = 0;
		free_total = 0;
		errors = 0;
	end

	assign pending = expected_rsp.size();

	function automatic bit [63:0] sat_sum(bit [63:0] a, bit [63:0] b);
		if (a > SUM_MAX) a = SUM_MAX;
		if (b > SUM_MAX - a) return SUM_MAX;
		return a + b;
	endfunction

	function automatic status_e insert_region(bit [63:0] addr, bit [63:0] len);
		bit [63:0] base, fin, size;
		int d;
		if (addr == 0) return ST_ZERO_BASE;
		if (rg_count >= NREG) return ST_TABLE_FULL;
		base = (addr + PG_MASK) & ~PG_MASK;
		fin = addr + len;
		if (base > fin) return ST_TOO_SMALL;
		size = (fin - base) & ~PG_MASK;
		if (size < PG) return ST_TOO_SMALL;
		if (base >= LIMIT || size > LIMIT - base) return ST_TOO_SMALL;
		for (int i = 0; i < rg_count; i++)
			if (rg_start[i] <= base && base <= rg_start[i] + rg_size[i]) return ST_MANAGED;
		if (spare_top == 0) return ST_NO_DESC;
		spare_top--;
		d = spare[spare_top] % NEXT;
		ext_start[d] = base;
		ext_size[d] = size;
		ext_link[d] = NEXT;
		rg_start[rg_count] = base;
		rg_size[rg_count] = size;
		rg_free[rg_count] = size;
		rg_head[rg_count] = d;
		rg_count++;
		managed_bytes = sat_sum(managed_bytes, size);
		free_total = sat_sum(free_total, size);
		return ST_OK;
	endfunction

	function automatic status_e alloc_pages(bit [63:0] len, bit [63:0] align,
			output bit [63:0] granted);
		bit [63:0] size, s, e, a;
		int cur, prev, steps, d;
		bit pre, post;
		granted = 0;
		if (len == 0) len = PG;
		size = (len + PG_MASK) & ~PG_MASK;
		if (align < PG || (align & (align - 1)) != 0) return ST_BAD_ALIGN;
		if (free_total < size) return ST_NO_MEMORY;
		for (int r = 0; r < rg_count; r++) begin
			if (rg_free[r] < size) continue;
			cur = rg_head[r];
			prev = NEXT;
			steps = 0;
			while (cur < NEXT && steps < NEXT) begin
				s = ext_start[cur];
				e = s + ext_size[cur];
				a = (s + (align - 1)) & ~(align - 1);
				steps++;
				if (a > e || size > e - a) begin
					prev = cur;
					cur = ext_link[cur];
					continue;
				end
				pre = a != s;
				post = e - a > size;
				if (pre && post) begin
					if (spare_top == 0) return ST_NO_DESC;
					spare_top--;
					d = spare[spare_top] % NEXT;
					ext_start[d] = a + size;
					ext_size[d] = e - (a + size);
					ext_link[d] = ext_link[cur];
					ext_link[cur] = d;
					ext_size[cur] = a - s;
				end else if (pre) begin
					ext_size[cur] = a - s;
				end else if (post) begin
					ext_start[cur] = a + size;
					ext_size[cur] = e - (a + size);
				end else begin
					// exact fit: unlink and give the descriptor back
					if (prev == NEXT) rg_head[r] = ext_link[cur];
					else ext_link[prev] = ext_link[cur];
					if (spare_top < NEXT) begin
						spare[spare_top] = cur;
						spare_top++;
					end
				end
				rg_free[r] -= size;
				free_total -= size;
				granted = a;
				return ST_OK;
			end
		end
		return ST_NO_MEMORY;
	endfunction

	function automatic rsp_t predict_result(req_t w);
		rsp_t o;
		bit [63:0] g;
		g = 0;
		if (w.operation == OP_ADD_REGION) o.status = insert_region(w.address, w.length);
		else o.status = alloc_pages(w.length, w.alignment, g);
		o.granted_address = g[ADDR_BITS-1:0];
		o.total_managed = managed_bytes[SUM_BITS-1:0];
		o.total_free = free_total[SUM_BITS-1:0];
		return o;
	endfunction

	always @(posedge clk) begin
		rsp_t exp_w;
		if (arst_n && req_valid && !req_stall) expected_rsp.push_back(predict_result(req));
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp.size() == 0) begin
				errors++;
				$display("%t unexpected result word %h", $realtime, rsp);
			end else begin
				exp_w = expected_rsp.pop_front();
				if (rsp.status !== exp_w.status) begin
					errors++;
					$display("%t status exp %0d got %0d", $realtime, exp_w.status, rsp.status);
				end
				if (rsp.granted_address !== exp_w.granted_address) begin
					errors++;
					$display("%t granted_address exp %h got %h", $realtime,
						exp_w.granted_address, rsp.granted_address);
				end
				if (rsp.total_managed !== exp_w.total_managed) begin
					errors++;
					$display("%t total_managed exp %h got %h", $realtime,
						exp_w.total_managed, rsp.total_managed);
				end
				if (rsp.total_free !== exp_w.total_free) begin
					errors++;
					$display("%t total_free exp %h got %h", $realtime,
						exp_w.total_free, rsp.total_free);
				end
			end
		end
	end

endmodule

>>> tb/sv/tb_first_fit_aligned_page_allocator.sv
// Testbench top for the first-fit aligned page allocator: clock, reset,
// request stimulus, result back-pressure and the verdict.
// Depends on ffa_pkg, first_fit_aligned_page_allocator and ffa_checker.
`timescale 1ns / 100ps

module tb_first_fit_aligned_page_allocator import ffa_pkg::*; ();

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	int   errors, pending;
	bit   hold_off = 1'b0;
	int   region_adds = 0;

	first_fit_aligned_page_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	ffa_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.errors(errors), .pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

	// random value in the low 56 bits
	function automatic logic [63:0] rand56();
		return {$urandom, $urandom} & 64'h00ff_ffff_ffff_ffff;
	endfunction

	function automatic req_t mk(operation_e op, logic [63:0] a, logic [63:0] l,
			logic [63:0] al);
		req_t w;
		w.operation = op;
		w.address = a[ADDR_BITS-1:0];
		w.length = l[ADDR_BITS-1:0];
		w.alignment = al[ADDR_BITS-1:0];
		return w;
	endfunction

	// gap of 0 keeps valid high into the next word
	task automatic send_word(req_t w, int gap);
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic req_t random_word(int n);
		int p;
		logic [63:0] base;
		p = $urandom_range(0, 99);
		if (n % 50 == 0 && region_adds < 10) begin
			base = (64'(region_adds) + 64'd3) << 32;
			region_adds++;
			return mk(OP_ADD_REGION, base + 64'($urandom_range(0, 4095)),
				64'($urandom_range(16, 256)) * 64'd4096 + 64'($urandom_range(0, 4095)),
				64'd0);
		end
		if (p < 8)
			return mk($urandom_range(0, 7) == 0 ? OP_ADD_REGION : OP_ALLOCATE,
				rand56(), rand56(), rand56());
		if (p < 14)
			return mk(OP_ALLOCATE, rand56(), 64'($urandom_range(0, 8 * 4096)),
				$urandom_range(0, 1) ? 64'($urandom_range(0, 4095)) : 64'($urandom));
		return mk(OP_ALLOCATE, rand56(), 64'($urandom_range(0, 8 * 4096)),
			64'h1 << $urandom_range(12, 17));
	endfunction

	// back-pressure in runs; one long hold on request
	initial begin
		int len;
		logic lvl;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				lvl = 1'b1;
				len = 400;
				hold_off = 1'b0;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin lvl = 1'b0; len = $urandom_range(20, 80); end
					3:       begin lvl = 1'b1; len = $urandom_range(10, 40); end
					4, 5:    begin lvl = 1'b1; len = $urandom_range(1, 3); end
					default: begin lvl = 1'b0; len = $urandom_range(1, 4); end
				endcase
			end
			rsp_stall <= lvl;
			repeat (len - 1) @(negedge clk);
		end
	end

	initial begin
		req_t dir [$];
		int n;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		dir.push_back(mk(OP_ADD_REGION, 0, 64'h10000, 0));
		dir.push_back(mk(OP_ADD_REGION, 64'h1001, 64'h1000, 0));
		dir.push_back(mk(OP_ADD_REGION, 64'h1_0000_0000, 64 * 4096, 0));
		dir.push_back(mk(OP_ADD_REGION, 64'h1_0000_0005, 64'h8000, 0));
		dir.push_back(mk(OP_ADD_REGION, (64'h1 << 56) - 64'h1000, 64'h2000, 0));
		dir.push_back(mk(OP_ADD_REGION, 64'h2_0000_0000, 32 * 4096 + 7, 0));
		dir.push_back(mk(OP_ALLOCATE, 0, 64'h1000, 0));
		dir.push_back(mk(OP_ALLOCATE, 0, 64'h1000, 64'h3000));
		dir.push_back(mk(OP_ALLOCATE, 0, 64'h1000, 64'h800));
		dir.push_back(mk(OP_ALLOCATE, 0, 0, 64'h1000));
		dir.push_back(mk(OP_ALLOCATE, 0, 5000, 64'h10000));
		dir.push_back(mk(OP_ALLOCATE, 0, (64'h1 << 56) - 1, 64'h1000));
		dir.push_back(mk(OP_ALLOCATE, 0, 64'h1000, 64'h1 << 55));
		dir.push_back(mk(OP_ALLOCATE, 0, 15 * 4096, 64'h1000));
		dir.push_back(mk(OP_ALLOCATE, 0, 64'hffffff, (64'h1 << 56) - 1));
		foreach (dir[i]) send_word(dir[i], pick_gap());

		for (n = 0; n < 550; n++) begin
			if (n == 200) hold_off = 1'b1;
			if (n == 350) begin
				req_valid <= 1'b0;
				wait (pending == 0);
				@(negedge clk);
			end
			send_word(random_word(n), (n >= 100 && n < 300) ? 0 : pick_gap());
		end

		// huge overlapping regions push both totals to saturation
		dir.delete();
		dir.push_back(mk(OP_ADD_REGION, 64'h1 << 55, 64'h1 << 55, 0));
		dir.push_back(mk(OP_ADD_REGION, 64'h1 << 54, (64'h1 << 56) - (64'h1 << 54), 0));
		dir.push_back(mk(OP_ADD_REGION, 64'h1 << 53, (64'h1 << 56) - (64'h1 << 53), 0));
		dir.push_back(mk(OP_ALLOCATE, 0, 64'h1 << 54, 64'h1 << 55));
		dir.push_back(mk(OP_ALLOCATE, 0, (64'h1 << 56) - 1, 64'h1000));
		for (int k = 0; k < 6; k++)
			dir.push_back(mk(OP_ADD_REGION, (64'h1 << 52) + (64'(k) << 40), 64'h100000, 0));
		dir.push_back(mk(OP_ALLOCATE, 0, 64'h1000, 64'h1 << 52));
		foreach (dir[i]) send_word(dir[i], pick_gap());
		req_valid <= 1'b0;

		wait (pending == 0);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> first_fit_aligned_page_allocator.f
rtl/ffa_pkg.sv
rtl/ffa_ctrl.sv
rtl/ffa_dp.sv
rtl/first_fit_aligned_page_allocator.sv
tb/sv/ffa_checker.sv
tb/sv/tb_first_fit_aligned_page_allocator.sv
